[rtl/iqfd_pkg.sv]
// Shared types, sizes and arithmetic helpers for the I/Q decimating FIR filter.
// Used by every module of the block; depends on nothing else.
package iqfd_pkg;

  // Storage and field sizes
  localparam int MAX_TAPS    = 128;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;

  localparam int TAP_W   = $clog2(MAX_TAPS);       // tap / memory address bits
  localparam int CNT_W   = TAP_W + 1;              // holds 0..MAX_TAPS
  localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W   = PROD_W + TAP_W;         // exact sum of MAX_TAPS products
  localparam int DL_W    = 2 * SAMPLE_BITS;        // one I/Q pair per delay-line word

  // Fixed field widths
  localparam int MODE_W      = 1;
  localparam int COEF_IDX_W  = 7;
  localparam int DEC_W       = 7;
  localparam int TAPCNT_W    = 8;
  localparam int PHASE_W     = 6;
  localparam int DEC_MAX     = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Input tdata layout (lowest bit first)
  localparam int IN_DATA_BITS = 2 * SAMPLE_BITS + COEF_IDX_W + COEF_BITS;
  localparam int IN_DATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam int SI_LSB = 0;
  localparam int SQ_LSB = SAMPLE_BITS;
  localparam int CI_LSB = 2 * SAMPLE_BITS;
  localparam int CV_LSB = 2 * SAMPLE_BITS + COEF_IDX_W;

  // Item kinds carried on in_tuser
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_COEF   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 2'd1;

  // Rounding and saturation constants at accumulator width plus one
  localparam logic signed [ACC_W:0] RND_HALF =
    {{(ACC_W + 2 - COEF_BITS){1'b0}}, 1'b1, {(COEF_BITS - 2){1'b0}}};
  localparam logic signed [ACC_W:0] SAT_HI =
    {{(ACC_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_LO =
    {{(ACC_W + 2 - SAMPLE_BITS){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } iqfd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic             sample_wr;
    logic             coef_wr;
    logic             acc_clr;
    logic             tap_issue;
    logic [TAP_W-1:0] tap_idx;
    logic             out_load;
  } iqfd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;
  } iqfd_sts_t;

  // Round to nearest (ties up) and saturate a Q9.30 sum to the sample format
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W:0] r;
    logic signed [ACC_W:0] v;
    r = {acc[ACC_W-1], acc} + RND_HALF;
    v = r >>> (COEF_BITS - 1);
    if (v > SAT_HI) begin
      v = SAT_HI;
    end else if (v < SAT_LO) begin
      v = SAT_LO;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

[rtl/iqfd_dp.sv]
// Datapath of the I/Q decimating FIR: coefficient memory, circular delay line,
// two multiply-accumulate lanes, rounding and the output register. Uses iqfd_pkg.
module iqfd_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  iqfd_pkg::iqfd_cmd_t                    cmd,
  input  logic signed [iqfd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic signed [iqfd_pkg::SAMPLE_BITS-1:0] sample_q,
  input  logic [iqfd_pkg::COEF_IDX_W-1:0]        coef_index,
  input  logic signed [iqfd_pkg::COEF_BITS-1:0]  coef_value,
  output iqfd_pkg::iqfd_sts_t                    sts,
  output logic signed [iqfd_pkg::SAMPLE_BITS-1:0] out_i,
  output logic signed [iqfd_pkg::SAMPLE_BITS-1:0] out_q
);

  logic [iqfd_pkg::COEF_BITS-1:0] coef_mem [iqfd_pkg::MAX_TAPS];
  logic [iqfd_pkg::DL_W-1:0]      dl_mem   [iqfd_pkg::MAX_TAPS];

  logic [iqfd_pkg::TAP_W-1:0] newest_r, newest_nxt;
  logic [iqfd_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [iqfd_pkg::TAP_W-1:0] wr_addr;
  logic [iqfd_pkg::TAP_W-1:0] rd_addr;
  logic                       coef_in_range;

  logic                              s1_vld_r, s1_live_r;
  logic [iqfd_pkg::COEF_BITS-1:0]    coef_rd_r;
  logic [iqfd_pkg::DL_W-1:0]         dl_rd_r;
  logic                              s2_vld_r;
  logic signed [iqfd_pkg::PROD_W-1:0] prod_i_r, prod_q_r;
  logic signed [iqfd_pkg::ACC_W-1:0]  acc_i_r, acc_q_r;
  logic signed [iqfd_pkg::SAMPLE_BITS-1:0] out_i_r, out_q_r;

  // Next write slot of the circular delay line
  always_comb begin
    if (32'(newest_r) == iqfd_pkg::MAX_TAPS - 1) begin
      wr_addr = '0;
    end else begin
      wr_addr = newest_r + 1'b1;
    end
  end

  // Address of tap tap_idx counted back from the newest sample
  always_comb begin
    if (newest_r >= cmd.tap_idx) begin
      rd_addr = newest_r - cmd.tap_idx;
    end else begin
      rd_addr = iqfd_pkg::TAP_W'(32'(newest_r) + iqfd_pkg::MAX_TAPS - 32'(cmd.tap_idx));
    end
  end

  // Advance pointer and fill count on each sample
  always_comb begin
    newest_nxt = newest_r;
    fill_nxt   = fill_r;
    if (cmd.sample_wr) begin
      newest_nxt = wr_addr;
      if (32'(fill_r) < iqfd_pkg::MAX_TAPS) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      fill_r   <= '0;
    end else begin
      newest_r <= newest_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign coef_in_range = 32'(coef_index) < iqfd_pkg::MAX_TAPS;

  // Coefficient memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && coef_in_range) begin
      coef_mem[iqfd_pkg::TAP_W'(coef_index)] <= coef_value;
    end
    coef_rd_r <= coef_mem[cmd.tap_idx];
  end

  // Delay-line memory: I in the low half, Q in the high half
  always_ff @(posedge clk) begin
    if (cmd.sample_wr) begin
      dl_mem[wr_addr] <= {sample_q, sample_i};
    end
    dl_rd_r <= dl_mem[rd_addr];
  end

  // Track taps through read and multiply stages; taps past the fill count read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_live_r <= 1'b0;
      s2_vld_r  <= 1'b0;
    end else begin
      s1_vld_r  <= cmd.tap_issue;
      s1_live_r <= {1'b0, cmd.tap_idx} < fill_r;
      s2_vld_r  <= s1_vld_r;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (s1_live_r) begin
      prod_i_r <= $signed(coef_rd_r) * $signed(dl_rd_r[iqfd_pkg::SAMPLE_BITS-1:0]);
      prod_q_r <= $signed(coef_rd_r) * $signed(dl_rd_r[iqfd_pkg::DL_W-1:iqfd_pkg::SAMPLE_BITS]);
    end else begin
      prod_i_r <= '0;
      prod_q_r <= '0;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (s2_vld_r) begin
      acc_i_r <= acc_i_r + iqfd_pkg::ACC_W'(prod_i_r);
      acc_q_r <= acc_q_r + iqfd_pkg::ACC_W'(prod_q_r);
    end
  end

  // Round, saturate and hold the result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_i_r <= iqfd_pkg::round_sat(acc_i_r);
      out_q_r <= iqfd_pkg::round_sat(acc_q_r);
    end
  end

  assign sts.busy = s1_vld_r | s2_vld_r;
  assign out_i    = out_i_r;
  assign out_q    = out_q_r;

endmodule

[rtl/iqfd_ctrl.sv]
// Controller of the I/Q decimating FIR: configuration registers, decimation phase,
// tap sequencing and output handshake. Uses iqfd_pkg.
module iqfd_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [iqfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iqfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [iqfd_pkg::MODE_W-1:0]         in_mode,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output iqfd_pkg::iqfd_cmd_t                 cmd,
  input  iqfd_pkg::iqfd_sts_t                 sts
);

  iqfd_pkg::iqfd_state_t state_r, state_nxt;

  logic [iqfd_pkg::DEC_W-1:0]    dec_r;
  logic [iqfd_pkg::TAPCNT_W-1:0] taps_r;
  logic [iqfd_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [iqfd_pkg::TAP_W-1:0]    tap_cnt_r, tap_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [iqfd_pkg::DEC_W-1:0] dec_eff;
  logic [iqfd_pkg::CNT_W-1:0] taps_eff;
  logic                       accept;
  logic                       accept_sample;
  logic                       emit;
  logic                       tap_last;
  logic                       out_free;

  // Clamp configuration to its working range
  always_comb begin
    if (dec_r == '0) begin
      dec_eff = iqfd_pkg::DEC_W'(1);
    end else if (32'(dec_r) > iqfd_pkg::DEC_MAX) begin
      dec_eff = iqfd_pkg::DEC_W'(iqfd_pkg::DEC_MAX);
    end else begin
      dec_eff = dec_r;
    end
  end

  always_comb begin
    if (taps_r == '0) begin
      taps_eff = iqfd_pkg::CNT_W'(1);
    end else if (32'(taps_r) > iqfd_pkg::MAX_TAPS) begin
      taps_eff = iqfd_pkg::CNT_W'(iqfd_pkg::MAX_TAPS);
    end else begin
      taps_eff = iqfd_pkg::CNT_W'(taps_r);
    end
  end

  assign accept        = in_tvalid && in_tready;
  assign accept_sample = accept && (in_mode == iqfd_pkg::MODE_SAMPLE);
  assign emit          = phase_r == '0;
  assign tap_last      = {1'b0, tap_cnt_r} == (taps_eff - 1'b1);
  assign out_free      = !out_valid_r || out_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r  <= iqfd_pkg::DEC_W'(1);
      taps_r <= iqfd_pkg::TAPCNT_W'(iqfd_pkg::MAX_TAPS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        iqfd_pkg::REG_DECIMATION: dec_r  <= cfg_data[iqfd_pkg::DEC_W-1:0];
        iqfd_pkg::REG_TAP_COUNT:  taps_r <= cfg_data[iqfd_pkg::TAPCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Decimation phase: count on each sample, wrap at the effective factor
  always_comb begin
    phase_nxt = phase_r;
    if (accept_sample) begin
      if ((32'(phase_r) + 1) >= 32'(dec_eff)) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt   = state_r;
    tap_cnt_nxt = tap_cnt_r;
    unique case (state_r)
      iqfd_pkg::ST_IDLE: begin
        tap_cnt_nxt = '0;
        if (accept_sample && emit) begin
          state_nxt = iqfd_pkg::ST_MAC;
        end
      end
      iqfd_pkg::ST_MAC: begin
        tap_cnt_nxt = tap_cnt_r + 1'b1;
        if (tap_last) begin
          state_nxt = iqfd_pkg::ST_DRAIN;
        end
      end
      iqfd_pkg::ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = iqfd_pkg::ST_FINISH;
        end
      end
      iqfd_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = iqfd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = iqfd_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      iqfd_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.coef_wr   = accept && (in_mode == iqfd_pkg::MODE_COEF);
        cmd.sample_wr = accept_sample;
        cmd.acc_clr   = accept_sample;
      end
      iqfd_pkg::ST_MAC: begin
        cmd.tap_issue = 1'b1;
        cmd.tap_idx   = tap_cnt_r;
      end
      iqfd_pkg::ST_DRAIN: ;
      iqfd_pkg::ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: ;
    endcase
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iqfd_pkg::ST_IDLE;
      phase_r     <= '0;
      tap_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[rtl/iq_fir_decimator_top.sv]
// Top level of the I/Q decimating FIR filter: stream ports, configuration port,
// controller and datapath. Depends on iqfd_pkg, iqfd_ctrl and iqfd_dp.
//
// Decimating FIR on interleaved I/Q pairs with one shared Q1.15 coefficient
// table of up to 128 taps; results are rounded to nearest and saturated to
// Q1.15. An item is taken only while the block is idle. A coefficient write,
// or a sample that produces no result, is taken and the block stays idle. A
// sample that produces a result is accepted, then one multiply-accumulate per
// channel steps through one tap a cycle, reading the coefficient memory and
// the delay-line memory once per tap, and the block then finishes the read,
// multiply, accumulate and rounding before it takes the next item. The delay
// line needs no clearing after reset: taps older than the samples received
// since reset count as zero. Coefficients must be written before use; the
// result register lets the next item enter while a result waits.
module iq_fir_decimator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [iqfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iqfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] sample_i, [31:16] sample_q, [38:32] coef_index, [54:39] coef_value
  input  logic [iqfd_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] mode
  input  logic [iqfd_pkg::MODE_W-1:0]         in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] out_i, [31:16] out_q
  output logic [iqfd_pkg::OUT_DATA_W-1:0]     out_tdata
);

  iqfd_pkg::iqfd_cmd_t cmd;
  iqfd_pkg::iqfd_sts_t sts;

  logic signed [iqfd_pkg::SAMPLE_BITS-1:0] out_i;
  logic signed [iqfd_pkg::SAMPLE_BITS-1:0] out_q;

  iqfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  iqfd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_i   (in_tdata[iqfd_pkg::SI_LSB +: iqfd_pkg::SAMPLE_BITS]),
    .sample_q   (in_tdata[iqfd_pkg::SQ_LSB +: iqfd_pkg::SAMPLE_BITS]),
    .coef_index (in_tdata[iqfd_pkg::CI_LSB +: iqfd_pkg::COEF_IDX_W]),
    .coef_value (in_tdata[iqfd_pkg::CV_LSB +: iqfd_pkg::COEF_BITS]),
    .sts        (sts),
    .out_i      (out_i),
    .out_q      (out_q)
  );

  // Pack the result, zero-fill to whole bytes
  assign out_tdata = iqfd_pkg::OUT_DATA_W'({out_q, out_i});

endmodule

[rtl/iqfd_chk.sv]
// Port-level checks for the I/Q decimating FIR top level, bound to every instance.
// Depends on iqfd_pkg and iq_fir_decimator_top.
module iqfd_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [iqfd_pkg::MODE_W-1:0]     in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [iqfd_pkg::OUT_DATA_W-1:0] out_tdata
);

  // No result is pending out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // A coefficient write never starts a computation
  a_coef_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == iqfd_pkg::MODE_COEF) |=> in_tready)
    else $error("coefficient write blocked the input");

  // A new result only appears at the end of a computation, while input is held off
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a computation");

endmodule

bind iq_fir_decimator_top iqfd_chk u_iqfd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
